// ===== rtl/grid_step_sequencer_unit_assert.svh =====
// Assertion macros for the grid step sequencer unit.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef GRID_STEP_SEQUENCER_UNIT_ASSERT_SVH
`define GRID_STEP_SEQUENCER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define GSQ_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("grid step sequencer check failed");

// The consequent holds in the same cycle as the antecedent.
`define GSQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid step sequencer check failed");

`else

`define GSQ_ASSERT_ALWAYS(label, clk, rst, expr)
`define GSQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/gsq_pkg.sv =====
package gsq_pkg;

   // Default grid geometry.
   localparam int GSQ_ROWS = 64;
   localparam int GSQ_COLS = 16;

   // Field widths.
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 48;
   localparam int BPM_W      = 26;
   localparam int BLK_W      = 13;
   localparam int RPB_W      = 5;
   localparam int SR_W       = 18;
   localparam int CELL_W     = 8;
   localparam int NOTE_W     = 7;
   localparam int OFF_W      = 12;
   localparam int CELL_ROW_W = 6;
   localparam int CELL_COL_W = 4;
   localparam int ROW_OUT_W  = 6;
   localparam int COL_OUT_W  = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 18;

   // Arithmetic widths of the offset datapath.
   localparam int PROD_W    = POS_W + RPB_W;
   localparam int DEN_W     = BPM_W + RPB_W;
   localparam int NUM_W     = FRAC_BITS + SR_W;
   localparam int SCALED_W  = NUM_W + 6;
   localparam int DIV_STEPS = 13;
   localparam int STEP_W    = 4;
   localparam int DSH_W     = DEN_W + DIV_STEPS - 1;
   localparam int LIMIT_W   = DEN_W + DIV_STEPS;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PER_BEAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 1'd1;
   localparam logic [RPB_W-1:0]     RPB_RESET         = 5'd4;
   localparam logic [SR_W-1:0]      SR_RESET          = 18'd44100;

   // Request kinds.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_CELL = 1'b1;

   // A cell with its top bit set is empty.
   localparam logic [CELL_W-1:0] CELL_EMPTY = 8'h80;
   localparam logic [OFF_W-1:0]  MAX_OFFSET = 12'hFFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SCALE,
      ST_RANGE,
      ST_DIV,
      ST_FIN,
      ST_CHK,
      ST_FLUSH
   } gsq_state_type;

endpackage

// ===== rtl/gsq_ram.sv =====
module gsq_ram
   import gsq_pkg::*;
#(
   parameter int WIDTH = CELL_W,
   parameter int DEPTH = GSQ_ROWS * GSQ_COLS
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/grid_step_sequencer_unit.sv =====
// Grid step sequencer. The block holds a grid of COLS by ROWS note cells in
// one synchronous RAM. A cell request (req_type high) stores one cell; a
// negative note clears the cell and an address outside the grid is dropped.
// A tick request while the transport plays computes the playhead row
// from the beat position and rows_per_beat, and when that row differs
// from the last triggered row it emits one note-on response per non-empty
// column, in column order, with rsp_last marking the final one.
// Cell requests and stopped ticks are handled in the idle state. A playing
// tick is taken in, multiplied and range checked, then the restoring divider
// converts the row fraction into samples (skipped when the tempo or speed is
// zero or the note falls before the block start); then the grid read starts,
// the RAM is swept one grid column at a time and the row is closed; a
// response stall can hold the sweep. The RAM read port and the divider set
// the length of a playing tick. A tick that repeats the last row finishes
// after the scale step. After reset the block clears all ROWS * COLS cells
// (1024 at the default size), one cell per cycle; requests stall during that
// pass while configuration writes are taken as usual. Responses sit in an
// output register, so the next request is taken while the last note-on of a
// row still waits on rsp_stall.
`include "grid_step_sequencer_unit_assert.svh"

module grid_step_sequencer_unit
   import gsq_pkg::*;
#(
   parameter int ROWS = GSQ_ROWS,
   parameter int COLS = GSQ_COLS
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic                     req_is_playing,
   input  logic [POS_W-1:0]         req_beat_position,
   input  logic [BPM_W-1:0]         req_tempo_bpm,
   input  logic [BLK_W-1:0]         req_block_samples,
   input  logic [CELL_ROW_W-1:0]    req_cell_row,
   input  logic [CELL_COL_W-1:0]    req_cell_col,
   input  logic signed [CELL_W-1:0] req_cell_note,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [NOTE_W-1:0]        rsp_note_number,
   output logic [OFF_W-1:0]         rsp_sample_offset,
   output logic [COL_OUT_W-1:0]     rsp_column,
   output logic [ROW_OUT_W-1:0]     rsp_playhead_row,
   output logic                     rsp_last
);

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   // Control state.
   gsq_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [RPB_W-1:0]  rpb_ff, rpb_in;
   logic [SR_W-1:0]   sr_ff, sr_in;
   logic              prev_valid_ff, prev_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers of the tick in flight.
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [BPM_W-1:0]    bpm_ff, bpm_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    prev_row_ff, prev_row_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [SCALED_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0]    dsh_ff, dsh_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                zero_ff, zero_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [NOTE_W-1:0]   pend_note_ff, pend_note_in;
   logic [COL_W-1:0]    pend_col_ff, pend_col_in;

   // Output register.
   logic [NOTE_W-1:0]    rsp_note_ff, rsp_note_in;
   logic [OFF_W-1:0]     rsp_off_ff, rsp_off_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Grid RAM port signals.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   // Helper values.
   logic                          req_accept;
   logic                          cell_in_grid;
   logic [ROW_W+CELL_ROW_W-1:0]   wr_row_wide;
   logic [COL_W+CELL_COL_W-1:0]   wr_col_wide;
   logic [PROD_W-1:0]             prod;
   logic [SCALED_W-1:0]           scaled;
   logic [LIMIT_W-1:0]            limit;
   logic [DSH_W-1:0]              div_diff;
   logic                          div_take;
   logic [DIV_STEPS:0]            q_plus_one;
   logic [BLK_W-1:0]              blk_diff;
   logic [OFF_W-1:0]              off_calc;
   logic                          out_free;
   logic                          push;
   logic                          push_last;
   logic                          cell_full;
   logic                          col_is_last;
   logic [ROW_W+ROW_OUT_W-1:0]    row_out_wide;
   logic [COL_W+COL_OUT_W-1:0]    col_out_wide;

   gsq_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Cell address, narrowed or widened to the grid geometry.
   assign wr_row_wide  = {{ROW_W{1'b0}}, req_cell_row};
   assign wr_col_wide  = {{COL_W{1'b0}}, req_cell_col};
   assign cell_in_grid = (32'(req_cell_row) < 32'(ROWS)) && (32'(req_cell_col) < 32'(COLS));

   // Row position: beat position times speed, integer part modulo ROWS.
   assign prod = PROD_W'(pos_ff) * PROD_W'(rpb_ff);

   // frac * sample_rate * 60 as (x << 6) - (x << 2).
   assign scaled = {num_ff, 6'b0} - {4'b0, num_ff, 2'b0};
   assign limit  = {den_ff, {DIV_STEPS{1'b0}}};

   // One restoring division step.
   assign div_take = ({3'b0, rem_ff} >= dsh_ff);
   assign div_diff = {3'b0, rem_ff} - dsh_ff;

   // Offset = max(block_samples - d - 1, 0), held to the 12-bit range.
   assign q_plus_one = {1'b0, q_ff} + (DIV_STEPS + 1)'(1);
   assign blk_diff   = blk_ff - q_plus_one[BLK_W-1:0];
   always_comb begin
      if (zero_ff || ({1'b0, blk_ff} <= q_plus_one)) begin
         off_calc = '0;
      end else if (blk_diff[BLK_W-1]) begin
         off_calc = MAX_OFFSET;
      end else begin
         off_calc = blk_diff[OFF_W-1:0];
      end
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign cell_full   = !rd_data[CELL_W-1];
   assign col_is_last = (col_ff == COL_W'(COLS - 1));

   assign row_out_wide = {{ROW_OUT_W{1'b0}}, row_ff};
   assign col_out_wide = {{COL_OUT_W{1'b0}}, pend_col_ff};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rpb_in        = rpb_ff;
      sr_in         = sr_ff;
      prev_valid_in = prev_valid_ff;
      prev_row_in   = prev_row_ff;
      pend_valid_in = pend_valid_ff;
      pend_note_in  = pend_note_ff;
      pend_col_in   = pend_col_ff;
      pos_in        = pos_ff;
      bpm_in        = bpm_ff;
      blk_in        = blk_ff;
      row_in        = row_ff;
      frac_in       = frac_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      zero_in       = zero_ff;
      off_in        = off_ff;
      base_in       = base_ff;
      col_in        = col_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = CELL_EMPTY;
      rd_en         = 1'b0;
      rd_addr       = base_ff;
      push          = 1'b0;
      push_last     = 1'b0;

      // Configuration writes are taken in every state.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_PER_BEAT: rpb_in = csr_data[RPB_W-1:0];
            CSR_SAMPLE_RATE:   sr_in  = csr_data[SR_W-1:0];
            default:           ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_CELL) begin
                  // A negative note already carries the empty flag in its sign bit.
                  wr_en   = cell_in_grid;
                  wr_addr = ADDR_W'(wr_row_wide[ROW_W-1:0]) * ADDR_W'(COLS)
                            + ADDR_W'(wr_col_wide[COL_W-1:0]);
                  wr_data = req_cell_note;
               end else if (req_is_playing) begin
                  pos_in   = req_beat_position;
                  bpm_in   = req_tempo_bpm;
                  blk_in   = req_block_samples;
                  state_in = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            row_in   = prod[FRAC_BITS +: ROW_W];
            frac_in  = prod[FRAC_BITS-1:0];
            den_in   = DEN_W'(bpm_ff) * DEN_W'(rpb_ff);
            state_in = ST_SCALE;
         end

         ST_SCALE: begin
            num_in  = NUM_W'(frac_ff) * NUM_W'(sr_ff);
            base_in = ADDR_W'(row_ff) * ADDR_W'(COLS);
            if (prev_valid_ff && (prev_row_ff == row_ff)) begin
               state_in = ST_IDLE;
            end else begin
               prev_row_in   = row_ff;
               prev_valid_in = 1'b1;
               state_in      = ST_RANGE;
            end
         end

         ST_RANGE: begin
            rem_in  = scaled;
            dsh_in  = {den_ff, {(DIV_STEPS - 1){1'b0}}};
            q_in    = '0;
            step_in = STEP_W'(DIV_STEPS - 1);
            // With no tempo or speed, or a sample count past any block, the offset is zero.
            if ((den_ff == '0) || ({4'b0, scaled} >= limit)) begin
               zero_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               zero_in  = 1'b0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_take) begin
               rem_in = div_diff[SCALED_W-1:0];
            end
            q_in    = {q_ff[DIV_STEPS-2:0], div_take};
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            off_in   = off_calc;
            col_in   = '0;
            rd_en    = 1'b1;
            rd_addr  = base_ff;
            state_in = ST_CHK;
         end

         ST_CHK: begin
            // A note is held back one step so that the final one can carry last.
            if (!(cell_full && pend_valid_ff && !out_free)) begin
               if (cell_full) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_note_in  = rd_data[NOTE_W-1:0];
                  pend_col_in   = col_ff;
               end
               if (col_is_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  col_in  = col_ff + COL_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = base_ff + ADDR_W'(col_ff + COL_W'(1));
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads the held note whenever it is free or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_note_in  = rsp_note_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_note_in  = pend_note_ff;
         rsp_off_in   = off_ff;
         rsp_col_in   = col_out_wide[COL_OUT_W-1:0];
         rsp_row_in   = row_out_wide[ROW_OUT_W-1:0];
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rpb_ff        <= RPB_RESET;
         sr_ff         <= SR_RESET;
         prev_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rpb_ff        <= rpb_in;
         sr_ff         <= sr_in;
         prev_valid_ff <= prev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_row_ff  <= prev_row_in;
      pend_note_ff <= pend_note_in;
      pend_col_ff  <= pend_col_in;
      pos_ff       <= pos_in;
      bpm_ff       <= bpm_in;
      blk_ff       <= blk_in;
      row_ff       <= row_in;
      frac_ff      <= frac_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      q_ff         <= q_in;
      step_ff      <= step_in;
      zero_ff      <= zero_in;
      off_ff       <= off_in;
      base_ff      <= base_in;
      col_ff       <= col_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_note_number   = rsp_note_ff;
   assign rsp_sample_offset = rsp_off_ff;
   assign rsp_column        = rsp_col_ff;
   assign rsp_playhead_row  = rsp_row_ff;
   assign rsp_last          = rsp_last_ff;

   // The grid RAM is never written and read in the same cycle.
   `GSQ_ASSERT_ALWAYS(a_no_rw_overlap, clock, reset, !(wr_en && rd_en))
   // Reads happen only while a row is swept.
   `GSQ_ASSERT_IMPLIES(a_rd_in_sweep, clock, reset, rd_en, (state_ff == ST_FIN) || (state_ff == ST_CHK))
   // No note is left behind once the block returns to idle.
   `GSQ_ASSERT_IMPLIES(a_pend_empty_idle, clock, reset, state_ff == ST_IDLE, !pend_valid_ff)
   // Restoring divider invariant: the remainder stays below twice the divisor.
   `GSQ_ASSERT_IMPLIES(a_div_bound, clock, reset, state_ff == ST_DIV, ({4'b0, rem_ff} < {dsh_ff, 1'b0}))

endmodule

// ===== bench/tb.sv =====
module tb;
   import gsq_pkg::*;

   // One expected note-on, as the block should present it on the response port.
   typedef struct {
      logic [NOTE_W-1:0]    note;
      logic [OFF_W-1:0]     offset;
      logic [COL_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0] row;
      logic                 last;
   } note_on_type;

   // Mirrors the note grid, the playhead and both registers, and keeps the
   // note-ons that the accepted requests still owe.
   class note_on_scoreboard;
      note_on_type          due_notes[$];
      bit                   cell_full[GSQ_ROWS*GSQ_COLS];
      logic [NOTE_W-1:0]    cell_pitch[GSQ_ROWS*GSQ_COLS];
      logic [RPB_W-1:0]     speed;
      logic [SR_W-1:0]      rate;
      logic [ROW_OUT_W-1:0] played_row;
      bit                   played_row_valid;
      int                   errors;

      function new();
         foreach (cell_full[i]) begin
            cell_full[i] = 1'b0;
            cell_pitch[i] = '0;
         end
         speed = RPB_RESET;
         rate = SR_RESET;
         played_row = '0;
         played_row_valid = 1'b0;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ROWS_PER_BEAT) begin
            speed = data[RPB_W-1:0];
         end else begin
            rate = data[SR_W-1:0];
         end
      endfunction

      function int pending();
         return due_notes.size();
      endfunction

      // Called for every accepted request.
      function void note_request(logic kind, logic playing, logic [POS_W-1:0] pos,
                                 logic [BPM_W-1:0] bpm, logic [BLK_W-1:0] blk,
                                 logic [CELL_ROW_W-1:0] crow, logic [CELL_COL_W-1:0] ccol,
                                 logic [CELL_W-1:0] cnote);
         logic [63:0]          prod;
         logic [63:0]          den;
         logic [63:0]          num;
         logic [63:0]          delay;
         logic [63:0]          offset;
         logic [ROW_OUT_W-1:0] row;
         int                   addr;
         int                   last_col;
         note_on_type          hit;
         if (kind == REQ_CELL) begin
            // Every address of the port lies inside the default grid.
            addr = int'(crow) * GSQ_COLS + int'(ccol);
            cell_full[addr] = !cnote[CELL_W-1];
            cell_pitch[addr] = cnote[CELL_W-1] ? '0 : cnote[NOTE_W-1:0];
            return;
         end
         if (!playing) begin
            return;
         end
         prod = 64'(pos) * 64'(speed);
         row = prod[FRAC_BITS +: ROW_OUT_W];
         if (played_row_valid && played_row == row) begin
            return;
         end
         played_row = row;
         played_row_valid = 1'b1;
         den = 64'(bpm) * 64'(speed);
         if (den == 64'd0) begin
            offset = 64'd0;
         end else begin
            num = 64'(prod[FRAC_BITS-1:0]) * 64'd60 * 64'(rate);
            delay = num / den;
            if (64'(blk) <= delay + 64'd1) begin
               offset = 64'd0;
            end else begin
               offset = 64'(blk) - delay - 64'd1;
               if (offset > 64'(MAX_OFFSET)) begin
                  offset = 64'(MAX_OFFSET);
               end
            end
         end
         last_col = -1;
         for (int c = 0; c < GSQ_COLS; c++) begin
            if (cell_full[int'(row) * GSQ_COLS + c]) begin
               last_col = c;
            end
         end
         for (int c = 0; c <= last_col; c++) begin
            addr = int'(row) * GSQ_COLS + c;
            if (cell_full[addr]) begin
               hit.note = cell_pitch[addr];
               hit.offset = offset[OFF_W-1:0];
               hit.column = COL_OUT_W'(c);
               hit.row = row;
               hit.last = (c == last_col);
               due_notes.push_back(hit);
            end
         end
      endfunction

      // Called for every accepted response.
      function void check_note_on(logic [NOTE_W-1:0] note, logic [OFF_W-1:0] offset,
                                  logic [COL_OUT_W-1:0] column, logic [ROW_OUT_W-1:0] row,
                                  logic last);
         note_on_type want;
         if (due_notes.size() == 0) begin
            $error("unexpected note-on: note %0d column %0d row %0d", note, column, row);
            errors++;
            return;
         end
         want = due_notes.pop_front();
         if (note !== want.note) begin
            $error("note_number: expected %0d, actual %0d", want.note, note);
            errors++;
         end
         if (offset !== want.offset) begin
            $error("sample_offset: expected %0d, actual %0d", want.offset, offset);
            errors++;
         end
         if (column !== want.column) begin
            $error("column: expected %0d, actual %0d", want.column, column);
            errors++;
         end
         if (row !== want.row) begin
            $error("playhead_row: expected %0d, actual %0d", want.row, row);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   // Every input of the block starts from a known value.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_type = REQ_TICK;
   logic                     req_is_playing = 1'b0;
   logic [POS_W-1:0]         req_beat_position = '0;
   logic [BPM_W-1:0]         req_tempo_bpm = '0;
   logic [BLK_W-1:0]         req_block_samples = '0;
   logic [CELL_ROW_W-1:0]    req_cell_row = '0;
   logic [CELL_COL_W-1:0]    req_cell_col = '0;
   logic signed [CELL_W-1:0] req_cell_note = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [NOTE_W-1:0]        rsp_note_number;
   logic [OFF_W-1:0]         rsp_sample_offset;
   logic [COL_OUT_W-1:0]     rsp_column;
   logic [ROW_OUT_W-1:0]     rsp_playhead_row;
   logic                     rsp_last;

   note_on_scoreboard sb;

   // Percent of cycles in which the sender idles and the receiver stalls.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // A long receiver hold-off is requested here and counted down by the
   // receiver process itself.
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;

   // Transport position that the random ticks walk forward.
   logic [POS_W-1:0] pos_cursor = '0;

   grid_step_sequencer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_is_playing    (req_is_playing),
      .req_beat_position (req_beat_position),
      .req_tempo_bpm     (req_tempo_bpm),
      .req_block_samples (req_block_samples),
      .req_cell_row      (req_cell_row),
      .req_cell_col      (req_cell_col),
      .req_cell_note     (req_cell_note),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_note_number   (rsp_note_number),
      .rsp_sample_offset (rsp_sample_offset),
      .rsp_column        (rsp_column),
      .rsp_playhead_row  (rsp_playhead_row),
      .rsp_last          (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both monitors sample at the rising edge, where the driven inputs still
   // hold the values of the cycle that ends there.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_type, req_is_playing, req_beat_position, req_tempo_bpm,
                         req_block_samples, req_cell_row, req_cell_col, req_cell_note);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_note_on(rsp_note_number, rsp_sample_offset, rsp_column,
                          rsp_playhead_row, rsp_last);
      end
   end

   // Receiver: random stalls, or a solid hold-off while one is being counted.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // The whole run fits in a small fraction of this, even with every row
   // full and every note-on stalled.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Playhead row that a position reaches at the current speed; used to aim
   // cell writes at rows that the transport is about to play.
   function automatic logic [ROW_OUT_W-1:0] row_at(logic [POS_W-1:0] pos);
      logic [63:0] prod;
      prod = 64'(pos) * 64'(sb.speed);
      return prod[FRAC_BITS +: ROW_OUT_W];
   endfunction

   // Writes both registers back to back. Call only while the block is idle.
   task automatic set_speed_and_rate(input int unsigned speed, input int unsigned rate);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROWS_PER_BEAT;
      csr_data <= CSR_DATA_W'(speed);
      @(posedge clock);
      sb.set_register(CSR_ROWS_PER_BEAT, CSR_DATA_W'(speed));
      csr_index <= CSR_SAMPLE_RATE;
      csr_data <= CSR_DATA_W'(rate);
      @(posedge clock);
      sb.set_register(CSR_SAMPLE_RATE, CSR_DATA_W'(rate));
      csr_wr_en <= 1'b0;
   endtask

   // Offers one request and returns at the edge where it is accepted. Valid
   // stays high so that the next request can follow without a gap; the idle
   // cycles before a request are decided without looking at the stall.
   task automatic offer_request(input logic kind, input logic playing,
                                input logic [POS_W-1:0] pos, input logic [BPM_W-1:0] bpm,
                                input logic [BLK_W-1:0] blk,
                                input logic [CELL_ROW_W-1:0] crow,
                                input logic [CELL_COL_W-1:0] ccol,
                                input logic [CELL_W-1:0] cnote);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_is_playing <= playing;
      req_beat_position <= pos;
      req_tempo_bpm <= bpm;
      req_block_samples <= blk;
      req_cell_row <= crow;
      req_cell_col <= ccol;
      req_cell_note <= cnote;
      do @(posedge clock); while (req_stall);
   endtask

   // The fields that a request kind does not use carry random noise.
   task automatic send_tick(input logic playing, input logic [POS_W-1:0] pos,
                            input logic [BPM_W-1:0] bpm, input logic [BLK_W-1:0] blk);
      offer_request(REQ_TICK, playing, pos, bpm, blk, CELL_ROW_W'($urandom),
                    CELL_COL_W'($urandom), CELL_W'($urandom));
   endtask

   task automatic send_cell(input logic [CELL_ROW_W-1:0] crow,
                            input logic [CELL_COL_W-1:0] ccol,
                            input logic [CELL_W-1:0] cnote);
      offer_request(REQ_CELL, 1'($urandom), POS_W'({$urandom, $urandom}),
                    BPM_W'($urandom), BLK_W'($urandom), crow, ccol, cnote);
   endtask

   // Lowers valid, waits for every owed note-on, then gives the block time to
   // finish a tick that owes none.
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (48) @(posedge clock);
   endtask

   // Mostly walks the transport forward by up to two rows, so that most ticks
   // land on a fresh row; some repeat the row and some jump anywhere.
   task automatic random_tick();
      int unsigned      r;
      int unsigned      span;
      logic [BPM_W-1:0] bpm;
      logic [BLK_W-1:0] blk;
      r = $urandom_range(99);
      span = (1 << (FRAC_BITS + 1)) / ((sb.speed == 0) ? 1 : int'(sb.speed));
      if (r < 8) begin
         pos_cursor = POS_W'({$urandom, $urandom});
      end else if (r >= 15) begin
         pos_cursor = pos_cursor + POS_W'($urandom_range(1, span));
      end
      r = $urandom_range(99);
      if (r < 5) begin
         bpm = '0;
      end else if (r < 15) begin
         bpm = BPM_W'($urandom_range(0, 65470464));
      end else begin
         bpm = BPM_W'($urandom_range(40 << FRAC_BITS, 300 << FRAC_BITS));
      end
      r = $urandom_range(99);
      if (r < 88) begin
         blk = BLK_W'($urandom_range(0, 4096));
      end else if (r < 95) begin
         blk = BLK_W'(4096);
      end else begin
         blk = BLK_W'($urandom_range(4097, 8191));
      end
      send_tick($urandom_range(99) < 95, pos_cursor, bpm, blk);
   endtask

   // Cell writes mostly fill the rows just ahead of the playhead, so that
   // ticks find notes; negative notes clear cells again.
   task automatic random_cell();
      int unsigned           r;
      logic [CELL_ROW_W-1:0] crow;
      logic [CELL_W-1:0]     cnote;
      if ($urandom_range(99) < 80) begin
         crow = row_at(pos_cursor) + CELL_ROW_W'($urandom_range(1, 4));
      end else begin
         crow = CELL_ROW_W'($urandom);
      end
      r = $urandom_range(99);
      if (r < 75) begin
         cnote = CELL_W'($urandom_range(0, 127));
      end else if (r < 85) begin
         cnote = CELL_W'(-1);
      end else begin
         cnote = CELL_W'($urandom_range(128, 255));
      end
      send_cell(crow, CELL_COL_W'($urandom), cnote);
   endtask

   initial begin : main
      int unsigned      pos_step;
      logic [POS_W-1:0] plan[6];
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The block clears its grid after reset and stalls requests meanwhile,
      // but takes register writes.
      set_speed_and_rate(32'(RPB_RESET), 32'(SR_RESET));

      // Directed requests at four rows per beat and 44.1 kHz. Row 0 gets the
      // lowest and highest note in the outer columns, row 1 one note after a
      // second one is cleared with a negative value, and row 63 a note in the
      // middle plus one in the last column; writing empty to an empty cell
      // must leave it empty.
      send_cell(0, 0, 0);
      send_cell(0, 15, 127);
      send_cell(1, 5, 60);
      send_cell(1, 6, 70);
      send_cell(1, 6, CELL_EMPTY);
      send_cell(63, 15, 127);
      send_cell(63, 0, CELL_W'(-1));
      send_cell(63, 8, 1);
      // A tick while stopped does nothing, not even record the row.
      send_tick(1'b0, '0, BPM_W'(120 << FRAC_BITS), 512);
      send_tick(1'b1, '0, BPM_W'(120 << FRAC_BITS), 512);
      // The same row again owes nothing.
      send_tick(1'b1, '0, BPM_W'(120 << FRAC_BITS), 512);
      // Zero tempo: the offset is zero without a divide.
      send_tick(1'b1, POS_W'(1 << 14), '0, 4096);
      // An empty row owes nothing but still counts as played.
      send_tick(1'b1, POS_W'(5 << 14), BPM_W'(120 << FRAC_BITS), 1000);
      // Largest block at the fastest tempo: the offset saturates.
      send_tick(1'b1, POS_W'(63 << 14), BPM_W'(65470464), 8191);
      // Row fraction near one at a slow tempo: the note falls before the
      // start of the block and the offset clamps to zero.
      send_tick(1'b1, POS_W'((1 << 14) + 16'h3FFF), BPM_W'(60 << FRAC_BITS), 4096);
      // Largest position, with an empty block.
      send_tick(1'b1, {POS_W{1'b1}}, BPM_W'(65470464), 0);
      // Smallest nonzero tempo with no row fraction.
      send_tick(1'b1, POS_W'(1 << 14), BPM_W'(1), 4096);
      quiesce();

      // Speed zero keeps the playhead on row 0 and skips the divide.
      set_speed_and_rate(0, 32'(SR_RESET));
      send_tick(1'b1, POS_W'({$urandom, $urandom}), BPM_W'(120 << FRAC_BITS), 2048);
      quiesce();

      // Speed beyond its range is used as written, and the rate field is at
      // its all-ones value. This is the first position that reaches row 65,
      // which wraps to row 1.
      set_speed_and_rate(31, 262143);
      send_tick(1'b1, POS_W'((65 << FRAC_BITS) / 31 + 1), BPM_W'(120 << FRAC_BITS), 1024);
      quiesce();

      set_speed_and_rate(16, 192000);
      send_tick(1'b1, '0, BPM_W'(90 << FRAC_BITS), 256);
      quiesce();

      set_speed_and_rate(1, 8000);
      send_tick(1'b1, POS_W'(63 << FRAC_BITS), BPM_W'(200 << FRAC_BITS), 300);
      quiesce();

      // Random phases, each with its own register setting and handshake mix.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_speed_and_rate(16, 192000);
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               set_speed_and_rate(1, 8000);
               req_idle_pct = 53;
               rsp_stall_pct = 0;
            end
            2: begin
               set_speed_and_rate($urandom_range(1, 16), $urandom_range(8000, 192000));
               req_idle_pct = 0;
               rsp_stall_pct = 53;
            end
            default: begin
               set_speed_and_rate(32'(RPB_RESET), 32'(SR_RESET));
               req_idle_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         pos_cursor = POS_W'($urandom_range(0, 1 << 20));
         for (int n = 0; n < 40; n++) begin
            if ($urandom_range(99) < 30) begin
               random_cell();
            end else begin
               random_tick();
            end
         end

         if (phase == 0) begin
            // Back pressure: fill six upcoming rows, then hold the receiver
            // off while ticks walk through them one row at a time. The single
            // response register fills at once and the block has to stall
            // its requests until the hold-off ends.
            pos_step = ((1 << FRAC_BITS) + int'(sb.speed) - 1) / int'(sb.speed);
            for (int k = 0; k < 6; k++) begin
               plan[k] = pos_cursor + POS_W'((k + 1) * pos_step);
               for (int j = 0; j < 4; j++) begin
                  send_cell(row_at(plan[k]), CELL_COL_W'($urandom),
                            CELL_W'($urandom_range(0, 127)));
               end
            end
            hold_request = 500;
            for (int k = 0; k < 6; k++) begin
               send_tick(1'b1, plan[k], BPM_W'($urandom_range(60 << FRAC_BITS,
                         180 << FRAC_BITS)), BLK_W'($urandom_range(0, 4096)));
            end
            pos_cursor = plan[5];
         end
         // The sender waits here until every owed note-on has come.
         quiesce();
      end

      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gsq_pkg.sv
rtl/gsq_ram.sv
rtl/grid_step_sequencer_unit.sv
bench/tb.sv
